### rtl/core/icc_pkg.sv
// Package for the incubator climate controller.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package icc_pkg;

   localparam int TEMP_W     = 15;
   localparam int HUM_W      = 10;
   localparam int TCORR_W    = 16;
   localparam int HCORR_W    = 12;
   localparam int TCMP_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_TEMP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_HYST       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_OFFSET     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AUX_THRESHOLD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HUMIDITY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMIDITY_HYST   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HUMIDITY_OFFSET = 3'd6;

   localparam logic [13:0]        RST_TARGET_TEMP     = 14'd3750;
   localparam logic [9:0]         RST_TEMP_HYST       = 10'd50;
   localparam logic signed [10:0] RST_TEMP_OFFSET     = 11'sd0;
   localparam logic [10:0]        RST_AUX_THRESHOLD   = 11'd200;
   localparam logic [9:0]         RST_TARGET_HUMIDITY = 10'd600;
   localparam logic [9:0]         RST_HUMIDITY_HYST   = 10'd100;
   localparam logic signed [8:0]  RST_HUMIDITY_OFFSET = 9'sd0;

   localparam logic signed [TEMP_W-1:0]  TEMP_MARK_LO = -15'sd6500;
   localparam logic signed [TEMP_W-1:0]  TEMP_MARK_HI = 15'sd13500;
   localparam logic signed [HCORR_W-1:0] HUM_MARK_LO  = -12'sd200;
   localparam logic signed [HCORR_W-1:0] HUM_MARK_HI  = 12'sd1200;

   typedef struct packed {
      logic [13:0]        target_temp;
      logic [9:0]         temp_hysteresis;
      logic signed [10:0] temp_offset;
      logic [10:0]        aux_heat_threshold;
      logic [9:0]         target_humidity;
      logic [9:0]         humidity_hysteresis;
      logic signed [8:0]  humidity_offset;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic signed [TCORR_W-1:0]  temp;
      logic signed [HCORR_W-1:0]  humidity;
      logic                       humidity_valid;
   } sample_type;

endpackage

### rtl/core/icc_req_if.sv
// Input channel of the incubator climate controller: one sample item.
// Depends on icc_pkg for field widths.
interface icc_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [icc_pkg::TEMP_W-1:0]      temp_sample;
   logic        [icc_pkg::HUM_W-1:0]       humidity_sample;
   logic                                   humidity_valid;

   modport source (output valid, temp_sample, humidity_sample, humidity_valid,
                   input ready);
   modport sink   (input valid, temp_sample, humidity_sample, humidity_valid,
                   output ready);
endinterface

### rtl/core/icc_rsp_if.sv
// Result channel of the incubator climate controller: relay drives and extremes.
// Depends on icc_pkg for field widths.
interface icc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  heater_on;
   logic                                  aux_heater_on;
   logic                                  cooler_on;
   logic                                  humidifier_on;
   logic                                  out_of_range_alarm;
   logic signed [icc_pkg::TEMP_W-1:0]     max_temp;
   logic signed [icc_pkg::TEMP_W-1:0]     min_temp;
   logic signed [icc_pkg::HCORR_W-1:0]    max_humidity;
   logic signed [icc_pkg::HCORR_W-1:0]    min_humidity;

   modport source (output valid, heater_on, aux_heater_on, cooler_on, humidifier_on,
                   out_of_range_alarm, max_temp, min_temp, max_humidity,
                   min_humidity, input ready);
   modport sink   (input valid, heater_on, aux_heater_on, cooler_on, humidifier_on,
                   out_of_range_alarm, max_temp, min_temp, max_humidity,
                   min_humidity, output ready);
endinterface

### rtl/core/incubator_climate_control_top.sv
// Top level of the incubator climate controller.
// Depends on icc_pkg, icc_req_if, icc_rsp_if, icc_csr, icc_input_stage, icc_control.
//
// The req_bus channel takes one item per cycle unless stalled: a temperature sample in
// hundredths of a degree, a humidity sample in tenths of a percent and a
// humidity valid flag. Each item gives exactly one result item on rsp_bus:
// the four relay drives, the out-of-range alarm and the running extremes.
// An item passes an input register, where the calibration offsets are added, and
// then the result register, where the thermostat and humidistat state is updated
// and which drives rsp_bus; one item a cycle is sustained while results are taken.
// The relay state and the result register are the same flip-flops, so each item
// sees the state left by the one before it. When the receiver stalls, the result
// holds and one further item waits in the input register; req_bus.ready then
// falls until the result is taken. Reset clears both stages, turns all relays off,
// sets the alarm, loads the extremes with their limits and restores every register
// to its default. Registers are written through csr_wr_en, csr_index and csr_wdata;
// the user must write them only while idle, as the block does not enforce it.
module incubator_climate_control_top (
   input  logic                            clock,
   input  logic                            reset,
   icc_req_if.sink                         req_bus,
   icc_rsp_if.source                       rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [icc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [icc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   icc_pkg::cfg_type    cfg;
   icc_pkg::sample_type sample;
   logic                take;

   icc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   icc_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cfg     (cfg),
      .take    (take),
      .sample  (sample)
   );

   icc_control u_control (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .sample  (sample),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

### rtl/core/icc_csr.sv
// Configuration registers of the incubator climate controller.
// Depends on icc_pkg for register indexes, reset values and cfg_type.
module icc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [icc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [icc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output icc_pkg::cfg_type                    cfg
);

   icc_pkg::cfg_type cfg_ff;
   icc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            icc_pkg::CSR_TARGET_TEMP:     cfg_in.target_temp         = csr_wdata[13:0];
            icc_pkg::CSR_TEMP_HYST:       cfg_in.temp_hysteresis     = csr_wdata[9:0];
            icc_pkg::CSR_TEMP_OFFSET:     cfg_in.temp_offset         = csr_wdata[10:0];
            icc_pkg::CSR_AUX_THRESHOLD:   cfg_in.aux_heat_threshold  = csr_wdata[10:0];
            icc_pkg::CSR_TARGET_HUMIDITY: cfg_in.target_humidity     = csr_wdata[9:0];
            icc_pkg::CSR_HUMIDITY_HYST:   cfg_in.humidity_hysteresis = csr_wdata[9:0];
            icc_pkg::CSR_HUMIDITY_OFFSET: cfg_in.humidity_offset     = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_temp         <= icc_pkg::RST_TARGET_TEMP;
         cfg_ff.temp_hysteresis     <= icc_pkg::RST_TEMP_HYST;
         cfg_ff.temp_offset         <= icc_pkg::RST_TEMP_OFFSET;
         cfg_ff.aux_heat_threshold  <= icc_pkg::RST_AUX_THRESHOLD;
         cfg_ff.target_humidity     <= icc_pkg::RST_TARGET_HUMIDITY;
         cfg_ff.humidity_hysteresis <= icc_pkg::RST_HUMIDITY_HYST;
         cfg_ff.humidity_offset     <= icc_pkg::RST_HUMIDITY_OFFSET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/icc_input_stage.sv
// Input register of the incubator climate controller: applies the offsets.
// Depends on icc_pkg and icc_req_if.
module icc_input_stage (
   input  logic               clock,
   input  logic               reset,
   icc_req_if.sink            req_bus,
   input  icc_pkg::cfg_type   cfg,
   input  logic               take,
   output icc_pkg::sample_type sample
);

   icc_pkg::sample_type sample_ff;
   logic                load;
   logic signed [icc_pkg::TCORR_W-1:0] temp_sum;
   logic signed [icc_pkg::HCORR_W-1:0] hum_sum;

   assign req_bus.ready = !sample_ff.valid || take;
   assign load          = req_bus.valid && req_bus.ready;

   assign temp_sum = icc_pkg::TCORR_W'(req_bus.temp_sample) + icc_pkg::TCORR_W'(cfg.temp_offset);
   assign hum_sum  = $signed({2'b00, req_bus.humidity_sample})
                   + icc_pkg::HCORR_W'(cfg.humidity_offset);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff.valid <= 1'b0;
      end else if (load) begin
         sample_ff.valid <= 1'b1;
      end else if (take) begin
         sample_ff.valid <= 1'b0;
      end
      if (load) begin
         sample_ff.temp           <= temp_sum;
         sample_ff.humidity       <= hum_sum;
         sample_ff.humidity_valid <= req_bus.humidity_valid;
      end
   end

   assign sample = sample_ff;

endmodule

### rtl/core/icc_control.sv
// Thermostat, humidistat and extreme tracking with the result register.
// Depends on icc_pkg and icc_rsp_if.
module icc_control (
   input  logic                clock,
   input  logic                reset,
   input  icc_pkg::cfg_type    cfg,
   input  icc_pkg::sample_type sample,
   output logic                take,
   icc_rsp_if.source           rsp_bus
);

   logic heating_ff, heating_in, cooling_ff, cooling_in, optimum_ff, optimum_in;
   logic heater_ff, heater_in, aux_ff, aux_in, cooler_ff, cooler_in, humid_ff, humid_in;
   logic signed [icc_pkg::TEMP_W-1:0]  temp_hi_ff, temp_hi_in, temp_lo_ff, temp_lo_in;
   logic signed [icc_pkg::HCORR_W-1:0] hum_hi_ff, hum_hi_in, hum_lo_ff, hum_lo_in;
   logic out_valid_ff;

   logic signed [icc_pkg::TCMP_W-1:0] t, tgt, lo_band, hi_band, aux_band;
   logic signed [icc_pkg::TEMP_W-1:0]  t_clamp;
   logic signed [icc_pkg::HCORR_W-1:0] h_clamp;

   assign take = sample.valid && (!out_valid_ff || rsp_bus.ready);

   assign t        = icc_pkg::TCMP_W'(sample.temp);
   assign tgt      = $signed({3'b000, cfg.target_temp});
   assign lo_band  = tgt - $signed({7'd0, cfg.temp_hysteresis});
   assign hi_band  = tgt + $signed({7'd0, cfg.temp_hysteresis});
   assign aux_band = tgt - $signed({6'd0, cfg.aux_heat_threshold});

   always_comb begin
      if (sample.temp < icc_pkg::TCORR_W'(icc_pkg::TEMP_MARK_LO)) begin
         t_clamp = icc_pkg::TEMP_MARK_LO;
      end else if (sample.temp > icc_pkg::TCORR_W'(icc_pkg::TEMP_MARK_HI)) begin
         t_clamp = icc_pkg::TEMP_MARK_HI;
      end else begin
         t_clamp = sample.temp[icc_pkg::TEMP_W-1:0];
      end
      if (sample.humidity < icc_pkg::HUM_MARK_LO) begin
         h_clamp = icc_pkg::HUM_MARK_LO;
      end else if (sample.humidity > icc_pkg::HUM_MARK_HI) begin
         h_clamp = icc_pkg::HUM_MARK_HI;
      end else begin
         h_clamp = sample.humidity;
      end
   end

   always_comb begin
      heating_in = heating_ff;
      cooling_in = cooling_ff;
      optimum_in = optimum_ff;
      heater_in  = heater_ff;
      aux_in     = aux_ff;
      cooler_in  = cooler_ff;
      temp_hi_in = (t_clamp > temp_hi_ff) ? t_clamp : temp_hi_ff;
      temp_lo_in = (t_clamp < temp_lo_ff) ? t_clamp : temp_lo_ff;
      hum_hi_in  = hum_hi_ff;
      hum_lo_in  = hum_lo_ff;
      humid_in   = 1'b0;

      if (t <= lo_band) begin
         cooler_in  = 1'b0;
         heater_in  = 1'b1;
         heating_in = 1'b1;
         cooling_in = 1'b0;
         optimum_in = 1'b0;
         if (t <= aux_band) begin
            aux_in = 1'b1;
         end
      end else if (t >= tgt && heating_ff) begin
         heater_in  = 1'b0;
         aux_in     = 1'b0;
         heating_in = 1'b0;
         optimum_in = 1'b1;
      end else if (t >= hi_band) begin
         heater_in  = 1'b0;
         aux_in     = 1'b0;
         cooler_in  = 1'b1;
         cooling_in = 1'b1;
         heating_in = 1'b0;
         optimum_in = 1'b0;
      end else if (t <= tgt && cooling_ff) begin
         cooler_in  = 1'b0;
         cooling_in = 1'b0;
         optimum_in = 1'b1;
      end
      if (optimum_in) begin
         heater_in = 1'b0;
         aux_in    = 1'b0;
         cooler_in = 1'b0;
      end

      if (sample.humidity_valid) begin
         hum_hi_in = (h_clamp > hum_hi_ff) ? h_clamp : hum_hi_ff;
         hum_lo_in = (h_clamp < hum_lo_ff) ? h_clamp : hum_lo_ff;
         humid_in  = sample.humidity < $signed({2'b00, cfg.target_humidity});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heating_ff   <= 1'b0;
         cooling_ff   <= 1'b0;
         optimum_ff   <= 1'b0;
         heater_ff    <= 1'b0;
         aux_ff       <= 1'b0;
         cooler_ff    <= 1'b0;
         humid_ff     <= 1'b0;
         temp_hi_ff   <= icc_pkg::TEMP_MARK_LO;
         temp_lo_ff   <= icc_pkg::TEMP_MARK_HI;
         hum_hi_ff    <= icc_pkg::HUM_MARK_LO;
         hum_lo_ff    <= icc_pkg::HUM_MARK_HI;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            heating_ff <= heating_in;
            cooling_ff <= cooling_in;
            optimum_ff <= optimum_in;
            heater_ff  <= heater_in;
            aux_ff     <= aux_in;
            cooler_ff  <= cooler_in;
            humid_ff   <= humid_in;
            temp_hi_ff <= temp_hi_in;
            temp_lo_ff <= temp_lo_in;
            hum_hi_ff  <= hum_hi_in;
            hum_lo_ff  <= hum_lo_in;
         end
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.heater_on          = heater_ff;
   assign rsp_bus.aux_heater_on      = aux_ff;
   assign rsp_bus.cooler_on          = cooler_ff;
   assign rsp_bus.humidifier_on      = humid_ff;
   assign rsp_bus.out_of_range_alarm = !optimum_ff;
   assign rsp_bus.max_temp           = temp_hi_ff;
   assign rsp_bus.min_temp           = temp_lo_ff;
   assign rsp_bus.max_humidity       = hum_hi_ff;
   assign rsp_bus.min_humidity       = hum_lo_ff;

endmodule

### rtl/core/icc_checker.sv
// Port-level checks for the incubator climate controller, bound to the top level.
// Depends on icc_pkg and incubator_climate_control_top.
module icc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                heater_on,
   input logic                                aux_heater_on,
   input logic                                cooler_on,
   input logic                                alarm,
   input logic signed [icc_pkg::TEMP_W-1:0]   max_temp
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("A result item is shown straight after reset.");

   a_optimum_relays_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !alarm |-> !heater_on && !aux_heater_on && !cooler_on)
      else $error("A temperature relay is on while the target is held.");

   a_aux_needs_heater: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && aux_heater_on |-> heater_on)
      else $error("The auxiliary heater runs without the main heater.");

   a_no_heat_and_cool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(heater_on && cooler_on))
      else $error("Heater and cooler are on together.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(heater_on) && $stable(max_temp))
      else $error("A stalled result item changed.");

endmodule

bind incubator_climate_control_top icc_checker u_icc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .heater_on     (rsp_bus.heater_on),
   .aux_heater_on (rsp_bus.aux_heater_on),
   .cooler_on     (rsp_bus.cooler_on),
   .alarm         (rsp_bus.out_of_range_alarm),
   .max_temp      (rsp_bus.max_temp)
);

### bench/incubator_climate_control_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the incubator climate controller top level.
// Drives sample items and register writes, predicts every result item and checks it.
// Depends on icc_pkg, icc_req_if, icc_rsp_if and incubator_climate_control_top.
module incubator_climate_control_top_tb;

   localparam logic [icc_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic signed [icc_pkg::TEMP_W-1:0] temp;
      logic [icc_pkg::HUM_W-1:0]         humidity;
      logic                              humidity_valid;
      logic                              hold;
   } sample_item_type;

   typedef struct packed {
      logic                                heater_on;
      logic                                aux_heater_on;
      logic                                cooler_on;
      logic                                humidifier_on;
      logic                                alarm;
      logic signed [icc_pkg::TEMP_W-1:0]   max_temp;
      logic signed [icc_pkg::TEMP_W-1:0]   min_temp;
      logic signed [icc_pkg::HCORR_W-1:0]  max_humidity;
      logic signed [icc_pkg::HCORR_W-1:0]  min_humidity;
   } climate_reading_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [icc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [icc_pkg::CSR_DATA_W-1:0] csr_wdata;

   icc_req_if req_bus ();
   icc_rsp_if rsp_bus ();

   incubator_climate_control_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   icc_pkg::cfg_type settings;
   bit heating, cooling, on_target;
   bit heater, aux_heater, cooler, humidifier;
   int temp_top = icc_pkg::TEMP_MARK_LO;
   int temp_bottom = icc_pkg::TEMP_MARK_HI;
   int hum_top = icc_pkg::HUM_MARK_LO;
   int hum_bottom = icc_pkg::HUM_MARK_HI;

   sample_item_type pending_samples[$];
   climate_reading_type expected_readings[$];
   sample_item_type outgoing;
   bit sending, req_fire, rsp_fire;
   int send_gap, send_calm, stall_left, stall_calm;
   int fault_count, stuck_cycles;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int saturate(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic climate_reading_type advance_climate(input sample_item_type s);
      climate_reading_type r;
      int t, tc, tgt, hys, aux, h;
      t = int'($signed(s.temp)) + int'($signed(settings.temp_offset));
      tgt = int'(settings.target_temp);
      hys = int'(settings.temp_hysteresis);
      aux = int'(settings.aux_heat_threshold);

      tc = saturate(t, icc_pkg::TEMP_MARK_LO, icc_pkg::TEMP_MARK_HI);
      temp_top = (tc > temp_top) ? tc : temp_top;
      temp_bottom = (tc < temp_bottom) ? tc : temp_bottom;

      if (t <= tgt - hys) begin
         cooler = 1'b0;
         heater = 1'b1;
         heating = 1'b1;
         cooling = 1'b0;
         on_target = 1'b0;
         if (t <= tgt - aux) aux_heater = 1'b1;
      end else if (t >= tgt && heating) begin
         heater = 1'b0;
         aux_heater = 1'b0;
         heating = 1'b0;
         on_target = 1'b1;
      end else if (t >= tgt + hys) begin
         heater = 1'b0;
         aux_heater = 1'b0;
         cooler = 1'b1;
         cooling = 1'b1;
         heating = 1'b0;
         on_target = 1'b0;
      end else if (t <= tgt && cooling) begin
         cooler = 1'b0;
         cooling = 1'b0;
         on_target = 1'b1;
      end
      if (on_target) begin
         heater = 1'b0;
         aux_heater = 1'b0;
         cooler = 1'b0;
      end

      if (s.humidity_valid) begin
         h = int'(s.humidity) + int'($signed(settings.humidity_offset));
         humidifier = (h < int'(settings.target_humidity));
         h = saturate(h, icc_pkg::HUM_MARK_LO, icc_pkg::HUM_MARK_HI);
         if (h > hum_top) hum_top = h;
         if (h < hum_bottom) hum_bottom = h;
      end else begin
         humidifier = 1'b0;
      end

      r.heater_on = heater;
      r.aux_heater_on = aux_heater;
      r.cooler_on = cooler;
      r.humidifier_on = humidifier;
      r.alarm = !on_target;
      r.max_temp = temp_top[icc_pkg::TEMP_W-1:0];
      r.min_temp = temp_bottom[icc_pkg::TEMP_W-1:0];
      r.max_humidity = hum_top[icc_pkg::HCORR_W-1:0];
      r.min_humidity = hum_bottom[icc_pkg::HCORR_W-1:0];
      return r;
   endfunction

   function automatic string describe(input climate_reading_type r);
      return $sformatf("heat %b aux %b cool %b hum %b alarm %b temp %0d..%0d humidity %0d..%0d",
                       r.heater_on, r.aux_heater_on, r.cooler_on, r.humidifier_on, r.alarm,
                       $signed(r.min_temp), $signed(r.max_temp),
                       $signed(r.min_humidity), $signed(r.max_humidity));
   endfunction

   always @(negedge clock) begin
      if (req_fire) sending = 1'b0;
      if (!reset && !sending) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_samples.size() > 0 &&
                      (!pending_samples[0].hold || expected_readings.size() == 0)) begin
            outgoing = pending_samples.pop_front();
            sending = 1'b1;
            send_gap = pick_gap(send_calm);
         end
      end
      req_bus.valid <= sending;
      if (sending) begin
         req_bus.temp_sample <= outgoing.temp;
         req_bus.humidity_sample <= outgoing.humidity;
         req_bus.humidity_valid <= outgoing.humidity_valid;
      end else begin
         req_bus.temp_sample <= icc_pkg::TEMP_W'($urandom);
         req_bus.humidity_sample <= icc_pkg::HUM_W'($urandom);
         req_bus.humidity_valid <= 1'($urandom);
      end
   end

   always @(negedge clock) begin
      if (rsp_fire) begin
         stall_left = pick_gap(stall_calm);
      end else if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      climate_reading_type seen, want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_fire = 1'b1;
            seen = '{rsp_bus.heater_on, rsp_bus.aux_heater_on, rsp_bus.cooler_on,
                     rsp_bus.humidifier_on, rsp_bus.out_of_range_alarm, rsp_bus.max_temp,
                     rsp_bus.min_temp, rsp_bus.max_humidity, rsp_bus.min_humidity};
            if (expected_readings.size() == 0) begin
               fault_count++;
               if (fault_count <= 40)
                  $display("%0t: unexpected result item: %s", $time, describe(seen));
            end else begin
               want = expected_readings.pop_front();
               if (seen !== want) begin
                  fault_count++;
                  if (fault_count <= 40)
                     $display("%0t: result mismatch\n   expected %s\n   actual   %s",
                              $time, describe(want), describe(seen));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_fire = 1'b1;
            expected_readings.push_back(advance_climate(outgoing));
         end
         if (req_fire || rsp_fire || csr_wr_en) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
               $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
               $display("DONE: errors detected");
               $finish;
            end
         end
      end
   end

   task automatic queue_sample(input int temp, input int humidity, input bit valid,
                               input bit hold = 1'b0);
      sample_item_type s;
      s.temp = icc_pkg::TEMP_W'(temp);
      s.humidity = icc_pkg::HUM_W'(humidity);
      s.humidity_valid = valid;
      s.hold = hold;
      pending_samples.push_back(s);
   endtask

   task automatic queue_random_samples(input int count);
      int tgt, hys, aux, toff, hum_aim, span, stride, walk, pause_at, roll;
      int edges[12];
      sample_item_type s;
      tgt = int'(settings.target_temp);
      hys = int'(settings.temp_hysteresis);
      aux = int'(settings.aux_heat_threshold);
      toff = int'($signed(settings.temp_offset));
      hum_aim = int'(settings.target_humidity) - int'($signed(settings.humidity_offset));
      span = hys + aux + 40;
      stride = span / 5 + 1;
      walk = tgt;
      pause_at = $urandom_range(count / 4, 3 * count / 4);
      edges = '{0, -1, 1, -hys, 1 - hys, -1 - hys, hys, hys - 1, hys + 1,
                -aux, 1 - aux, -1 - aux};
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 9);
         if (roll < 2) begin
            s.temp = icc_pkg::TEMP_W'($urandom);
         end else begin
            if (roll < 4)
               walk = tgt + edges[$urandom_range(0, 11)];
            else
               walk = saturate(walk + int'($urandom_range(0, 2 * stride)) - stride,
                               tgt - span, tgt + span);
            s.temp = icc_pkg::TEMP_W'(saturate(walk - toff, -16384, 16383));
         end
         if ($urandom_range(0, 3) == 0)
            s.humidity = icc_pkg::HUM_W'($urandom);
         else
            s.humidity = icc_pkg::HUM_W'(saturate(hum_aim + int'($urandom_range(0, 8)) - 4,
                                                  0, 1023));
         s.humidity_valid = ($urandom_range(0, 7) != 0);
         s.hold = (n == pause_at);
         pending_samples.push_back(s);
      end
   endtask

   task automatic write_register(input logic [icc_pkg::CSR_IDX_W-1:0] index, input int value,
                                 input int width);
      logic [icc_pkg::CSR_DATA_W-1:0] word;
      word = icc_pkg::CSR_DATA_W'($urandom);
      for (int b = 0; b < width; b++) word[b] = value[b];
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= word;
      case (index)
         icc_pkg::CSR_TARGET_TEMP:     settings.target_temp = word[13:0];
         icc_pkg::CSR_TEMP_HYST:       settings.temp_hysteresis = word[9:0];
         icc_pkg::CSR_TEMP_OFFSET:     settings.temp_offset = word[10:0];
         icc_pkg::CSR_AUX_THRESHOLD:   settings.aux_heat_threshold = word[10:0];
         icc_pkg::CSR_TARGET_HUMIDITY: settings.target_humidity = word[9:0];
         icc_pkg::CSR_HUMIDITY_HYST:   settings.humidity_hysteresis = word[9:0];
         icc_pkg::CSR_HUMIDITY_OFFSET: settings.humidity_offset = word[8:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input int tgt, input int hys, input int toff, input int aux,
                                 input int thum, input int hhys, input int hoff);
      write_register(icc_pkg::CSR_TARGET_TEMP, tgt, 14);
      write_register(icc_pkg::CSR_TEMP_HYST, hys, 10);
      write_register(icc_pkg::CSR_TEMP_OFFSET, toff, 11);
      write_register(icc_pkg::CSR_AUX_THRESHOLD, aux, 11);
      write_register(icc_pkg::CSR_TARGET_HUMIDITY, thum, 10);
      write_register(icc_pkg::CSR_HUMIDITY_HYST, hhys, 10);
      write_register(icc_pkg::CSR_HUMIDITY_OFFSET, hoff, 9);
      write_register(CSR_SPARE_INDEX, $urandom, 14);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_typical_settings();
      write_settings($urandom_range(3000, 4500), $urandom_range(10, 150),
                     int'($urandom_range(0, 200)) - 100, $urandom_range(50, 400),
                     $urandom_range(400, 800), $urandom_range(0, 200),
                     int'($urandom_range(0, 60)) - 30);
   endtask

   task automatic settle();
      while (pending_samples.size() != 0 || sending || expected_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = icc_pkg::CSR_TARGET_TEMP;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.temp_sample = '0;
      req_bus.humidity_sample = '0;
      req_bus.humidity_valid = 1'b0;
      rsp_bus.ready = 1'b0;
      settings.target_temp = icc_pkg::RST_TARGET_TEMP;
      settings.temp_hysteresis = icc_pkg::RST_TEMP_HYST;
      settings.temp_offset = icc_pkg::RST_TEMP_OFFSET;
      settings.aux_heat_threshold = icc_pkg::RST_AUX_THRESHOLD;
      settings.target_humidity = icc_pkg::RST_TARGET_HUMIDITY;
      settings.humidity_hysteresis = icc_pkg::RST_HUMIDITY_HYST;
      settings.humidity_offset = icc_pkg::RST_HUMIDITY_OFFSET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the default settings: no valid humidity yet, then the full heating and
      // cooling cycles, the direct swing from cooling to heating and the range limits.
      queue_sample(3750, 600, 1'b0);
      queue_sample(3700, 599, 1'b0);
      queue_sample(3550, 599, 1'b1);
      queue_sample(3720, 600, 1'b1);
      queue_sample(3749, 1023, 1'b1);
      queue_sample(3750, 0, 1'b1);
      queue_sample(3799, 500, 1'b0);
      queue_sample(3800, 500, 1'b1);
      queue_sample(3751, 601, 1'b1);
      queue_sample(3750, 599, 1'b1);
      queue_sample(3701, 700, 1'b1, 1'b1);
      queue_sample(3700, 700, 1'b1);
      queue_sample(3800, 700, 1'b1);
      queue_sample(3800, 700, 1'b1);
      queue_sample(3549, 100, 1'b1);
      queue_sample(16383, 1023, 1'b1);
      queue_sample(16383, 1023, 1'b1);
      queue_sample(-16384, 0, 1'b1);
      queue_sample(-16384, 0, 1'b0);
      queue_sample(3650, 512, 1'b1);
      settle();

      write_typical_settings();
      queue_random_samples(200);
      settle();

      write_settings(0, 0, -1024, 0, 0, 0, -256);
      queue_random_samples(100);
      settle();

      write_settings(16383, 1023, 1023, 2047, 1023, 1023, 255);
      queue_random_samples(100);
      settle();

      write_settings(3750, 0, int'($urandom_range(0, 40)) - 20, $urandom_range(0, 100),
                     600, 100, 0);
      queue_random_samples(120);
      settle();

      write_settings($urandom_range(0, 16383), $urandom_range(0, 1023),
                     int'($urandom_range(0, 2047)) - 1024, $urandom_range(0, 2047),
                     $urandom_range(0, 1023), $urandom_range(0, 1023),
                     int'($urandom_range(0, 511)) - 256);
      queue_random_samples(150);
      settle();

      write_typical_settings();
      queue_random_samples(160);
      settle();

      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
